// ===== sv/pausable_guest_clock_and_tick_counter_macros.svh =====
// Assertion macros for the pausable guest clock and tick counter.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef PAUSABLE_GUEST_CLOCK_AND_TICK_COUNTER_MACROS_SVH
`define PAUSABLE_GUEST_CLOCK_AND_TICK_COUNTER_MACROS_SVH
`ifndef SYNTHESIS
`define PGCTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PGCTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PGCTC_ASSERT_IMP(lbl, ante, cons)
`define PGCTC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/pgctc_pkg.sv =====
// Shared types and constants for the pausable guest clock and tick counter.
// No dependencies.
`default_nettype none
package pgctc_pkg;
  localparam int COUNTER_BITS_DEF = 20;
  localparam int MODE_W = 4;
  localparam int IN_DATA_W = 192;
  localparam int OUT_DATA_W = 72;
  localparam logic [MODE_W-1:0] MODE_COUNT = 4'd12;

  typedef enum logic [MODE_W-1:0] {
    OP_RD_TICKS, OP_RD_CLOCK, OP_ENABLE, OP_DISABLE, OP_WIN_OPEN, OP_WIN_CLOSE,
    OP_LOOP_ENTER, OP_LOOP_EXIT, OP_EXEC_ENTER, OP_EXEC_EXIT, OP_ARM, OP_LOCK, OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [62:0] host_ns;
    logic [62:0] host_ticks;
    logic [63:0] rate;
  } item_t;
endpackage
`default_nettype wire

// ===== sv/pgctc_front.sv =====
// Front end: registers an incoming word and decodes its mode into an operation.
// Depends on pgctc_pkg.
`default_nettype none
module pgctc_front import pgctc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [MODE_W-1:0]    in_tuser,
  input  wire logic                 q_ready,
  output logic                      q_push,
  output item_t                     q_item
);
  logic  v_r;
  item_t item_r;
  item_t item_nxt;

  assign in_tready = !v_r || q_ready;
  assign q_push    = v_r;
  assign q_item    = item_r;

  always_comb begin
    item_nxt.host_ns    = in_tdata[62:0];
    item_nxt.host_ticks = in_tdata[125:63];
    item_nxt.rate       = in_tdata[189:126];
    if (in_tuser < MODE_COUNT) begin
      item_nxt.op = op_t'(in_tuser);
    end else begin
      item_nxt.op = OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_tready) begin
      v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== sv/pgctc_queue.sv =====
// Two-entry queue between the front end and the execution back end.
// Depends on pgctc_pkg.
`default_nettype none
module pgctc_queue import pgctc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       push_ready,
  output logic       pop_valid,
  output item_t      pop_item,
  input  wire logic  pop
);
  item_t      mem [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       do_push;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = mem[rd_r];
  assign do_push    = push && push_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/pgctc_back.sv =====
// Back end: guest clock state, event execution, Q32 multiply pipeline, output register.
// Depends on pgctc_pkg and the assertion macro header.
`default_nettype none
`include "pausable_guest_clock_and_tick_counter_macros.svh"
module pgctc_back import pgctc_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire item_t                 q_item,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);
  typedef logic [COUNTER_BITS-1:0] cnt_t;

  logic [63:0] tick_off_r, tick_off_nxt, clock_off_r, clock_off_nxt;
  logic [63:0] last_r, last_nxt, frozen_r, frozen_nxt;
  logic [63:0] tick_rate_r, tick_rate_nxt, ref_ticks_r, ref_ticks_nxt;
  logic [63:0] ref_clock_r, ref_clock_nxt;
  logic        running_r, running_nxt, armed_r, armed_nxt;
  cnt_t        ow_r, ow_nxt, lc_r, lc_nxt, gc_r, gc_nxt;

  logic [63:0] ns64, ht64, base_ns, clk_now, t_raw, t_rd, toff_rd;
  logic        clamp, up, sat, was, now_held, held_arm;
  cnt_t        cnt_cur, cnt_new, ow_c, lc_c, gc_c;
  logic [63:0] value_c, mul_a_c;
  logic        mul_c, err_c, stop_c;

  logic        adv;
  logic        v1_r, mul1_r, stop1_r, err1_r;
  logic [63:0] a1_r, b1_r, ref1_r, val1_r;
  logic        v2_r, mul2_r, stop2_r, err2_r;
  logic [63:0] p00_r, p01_r, p10_r, p11_r, ref2_r, val2_r;
  logic        v3_r, stop3_r, err3_r;
  logic [63:0] val3_r;
  logic [33:0] mid;
  logic [63:0] hi;

  assign adv   = !v3_r || out_tready;
  assign q_pop = adv && q_valid;

  assign ns64    = {1'b0, q_item.host_ns};
  assign ht64    = {1'b0, q_item.host_ticks};
  assign base_ns = (frozen_r != 64'd0) ? frozen_r : ns64;
  assign clk_now = clock_off_r + (running_r ? base_ns : 64'd0);
  assign t_raw   = tick_off_r + (running_r ? ht64 : 64'd0);
  assign clamp   = $signed(last_r) > $signed(t_raw);
  assign t_rd    = clamp ? last_r : t_raw;
  assign toff_rd = clamp ? tick_off_r + (last_r - t_raw) : tick_off_r;

  // Select the counter that this operation moves and work out its saturated step.
  always_comb begin
    up      = (q_item.op == OP_WIN_OPEN) || (q_item.op == OP_LOOP_ENTER) ||
              (q_item.op == OP_EXEC_ENTER);
    cnt_cur = ow_r;
    if ((q_item.op == OP_LOOP_ENTER) || (q_item.op == OP_LOOP_EXIT)) cnt_cur = lc_r;
    if ((q_item.op == OP_EXEC_ENTER) || (q_item.op == OP_EXEC_EXIT)) cnt_cur = gc_r;
    sat     = up ? (cnt_cur == '1) : (cnt_cur == '0);
    cnt_new = up ? cnt_cur + cnt_t'(1) : cnt_cur - cnt_t'(1);
    ow_c = ow_r;
    lc_c = lc_r;
    gc_c = gc_r;
    if (!sat) begin
      if ((q_item.op == OP_WIN_OPEN) || (q_item.op == OP_WIN_CLOSE)) ow_c = cnt_new;
      if ((q_item.op == OP_LOOP_ENTER) || (q_item.op == OP_LOOP_EXIT)) lc_c = cnt_new;
      if ((q_item.op == OP_EXEC_ENTER) || (q_item.op == OP_EXEC_EXIT)) gc_c = cnt_new;
    end
    was      = (ow_r != '0) || (armed_r && (lc_r != '0) && (gc_r == '0));
    now_held = (ow_c != '0) || (armed_r && (lc_c != '0) && (gc_c == '0));
    held_arm = (ow_r != '0) || ((lc_r != '0) && (gc_r == '0));
  end

  always_comb begin
    tick_off_nxt  = tick_off_r;
    clock_off_nxt = clock_off_r;
    last_nxt      = last_r;
    frozen_nxt    = frozen_r;
    tick_rate_nxt = tick_rate_r;
    ref_ticks_nxt = ref_ticks_r;
    ref_clock_nxt = ref_clock_r;
    running_nxt   = running_r;
    armed_nxt     = armed_r;
    ow_nxt        = ow_r;
    lc_nxt        = lc_r;
    gc_nxt        = gc_r;
    value_c       = 64'd0;
    mul_c         = 1'b0;
    mul_a_c       = clk_now - ref_clock_r;
    err_c         = 1'b0;
    unique case (q_item.op)
      OP_RD_TICKS: begin
        if (tick_rate_r != 64'd0) begin
          mul_c = 1'b1;
        end else begin
          value_c      = t_rd;
          tick_off_nxt = toff_rd;
          last_nxt     = t_rd;
        end
      end
      OP_RD_CLOCK: value_c = clk_now;
      OP_ENABLE: begin
        if (!running_r) begin
          tick_off_nxt  = tick_off_r - ht64;
          clock_off_nxt = clock_off_r - ns64;
          running_nxt   = 1'b1;
          frozen_nxt    = was ? ns64 : 64'd0;
        end
      end
      OP_DISABLE: begin
        if (running_r) begin
          tick_off_nxt  = tick_off_r + ht64;
          clock_off_nxt = clk_now;
          running_nxt   = 1'b0;
          frozen_nxt    = 64'd0;
        end
      end
      OP_WIN_OPEN, OP_WIN_CLOSE, OP_LOOP_ENTER, OP_LOOP_EXIT,
      OP_EXEC_ENTER, OP_EXEC_EXIT: begin
        err_c  = sat;
        ow_nxt = ow_c;
        lc_nxt = lc_c;
        gc_nxt = gc_c;
        if (!sat && (was != now_held)) begin
          if (now_held) begin
            frozen_nxt = ns64;
          end else if (frozen_r != 64'd0) begin
            if (running_r) clock_off_nxt = clock_off_r - (ns64 - frozen_r);
            frozen_nxt = 64'd0;
          end
        end
      end
      OP_ARM: begin
        armed_nxt = 1'b1;
        if (held_arm && (frozen_r == 64'd0)) frozen_nxt = ns64;
      end
      OP_LOCK: begin
        if ((q_item.rate != 64'd0) && (tick_rate_r == 64'd0)) begin
          tick_off_nxt  = toff_rd;
          last_nxt      = t_rd;
          ref_ticks_nxt = t_rd;
          ref_clock_nxt = clk_now;
          tick_rate_nxt = q_item.rate;
        end
      end
      default: ;
    endcase
    stop_c = (ow_nxt != '0) || (armed_nxt && (lc_nxt != '0) && (gc_nxt == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_off_r  <= '0;
      clock_off_r <= '0;
      last_r      <= '0;
      frozen_r    <= '0;
      tick_rate_r <= '0;
      ref_ticks_r <= '0;
      ref_clock_r <= '0;
      running_r   <= 1'b0;
      armed_r     <= 1'b0;
      ow_r        <= '0;
      lc_r        <= '0;
      gc_r        <= '0;
    end else if (q_pop) begin
      tick_off_r  <= tick_off_nxt;
      clock_off_r <= clock_off_nxt;
      last_r      <= last_nxt;
      frozen_r    <= frozen_nxt;
      tick_rate_r <= tick_rate_nxt;
      ref_ticks_r <= ref_ticks_nxt;
      ref_clock_r <= ref_clock_nxt;
      running_r   <= running_nxt;
      armed_r     <= armed_nxt;
      ow_r        <= ow_nxt;
      lc_r        <= lc_nxt;
      gc_r        <= gc_nxt;
    end
  end

  // The locked tick read takes bits 32 to 95 of a 64 by 64 product,
  // built from four 32 by 32 partial products.
  assign mid = {2'b0, p00_r[63:32]} + {2'b0, p01_r[31:0]} + {2'b0, p10_r[31:0]};
  assign hi  = p11_r + {32'b0, p01_r[63:32]} + {32'b0, p10_r[63:32]} + {62'b0, mid[33:32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul1_r  <= mul_c;
      a1_r    <= mul_a_c;
      b1_r    <= tick_rate_r;
      ref1_r  <= ref_ticks_r;
      val1_r  <= value_c;
      stop1_r <= stop_c;
      err1_r  <= err_c;
      mul2_r  <= mul1_r;
      p00_r   <= a1_r[31:0] * b1_r[31:0];
      p01_r   <= a1_r[31:0] * b1_r[63:32];
      p10_r   <= a1_r[63:32] * b1_r[31:0];
      p11_r   <= a1_r[63:32] * b1_r[63:32];
      ref2_r  <= ref1_r;
      val2_r  <= val1_r;
      stop2_r <= stop1_r;
      err2_r  <= err1_r;
      val3_r  <= mul2_r ? ref2_r + {hi[31:0], mid[31:0]} : val2_r;
      stop3_r <= stop2_r;
      err3_r  <= err2_r;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {6'b0, err3_r, stop3_r, val3_r};

  `PGCTC_ASSERT_NXT(a_disable_clears, q_pop && (q_item.op == OP_DISABLE) && running_r, !running_r && (frozen_r == 64'd0))
  `PGCTC_ASSERT_NXT(a_lock_sticks, tick_rate_r != 64'd0, tick_rate_r != 64'd0)
  `PGCTC_ASSERT_NXT(a_arm_sets, q_pop && (q_item.op == OP_ARM), armed_r)
endmodule
`default_nettype wire

// ===== sv/pausable_guest_clock_and_tick_counter.sv =====
// Pausable guest clock and tick counter, top level.
// Path: from the accepting edge to out_tvalid, a word passes through five registers
// (front register, queue entry, execute stage, partial-product stage, output register).
// Throughput: one word per cycle while out_tready is high; all event state updates in the single execute stage.
// A held out_tready stalls the back end, fills the queue and then drops in_tready.
// Reset: synchronous active-low rst_n; clock disabled, counters and offsets zero.
`default_nettype none
module pausable_guest_clock_and_tick_counter import pgctc_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // host_ns, host_ticks, rate_q32, zero pad
  input  wire logic [MODE_W-1:0]     in_tuser,   // mode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // value, stopped, count_error, zero pad
);
  logic  q_push, q_ready, q_valid, q_pop;
  item_t q_in, q_out;

  pgctc_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_ready, .q_push, .q_item(q_in)
  );

  pgctc_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_item(q_in), .push_ready(q_ready),
    .pop_valid(q_valid), .pop_item(q_out), .pop(q_pop)
  );

  pgctc_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_item(q_out), .q_pop,
    .out_tvalid, .out_tready, .out_tdata
  );
endmodule
`default_nettype wire

// ===== test/pgctc_checker.sv =====
// Checker for the pausable guest clock and tick counter: watches both streams,
// predicts each result word from its own copy of the clock state and compares.
// Depends on pgctc_pkg.
`timescale 1ns / 100ps
module pgctc_checker import pgctc_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [MODE_W-1:0]     in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  output int                         fail_count,
  output int                         pending
);
  typedef struct packed {
    logic [63:0] value;
    logic        stopped;
    logic        count_error;
  } event_result_t;

  localparam logic [63:0] CTR_MAX = (64'd1 << COUNTER_BITS) - 64'd1;
  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  logic [63:0] tick_ofs, clock_ofs, prev_ticks, stamp, rate_lock, base_ticks, base_clock;
  logic [63:0] windows, loops, guests;
  logic        running, armed;
  event_result_t result_fifo[$];

  assign pending = result_fifo.size();

  function automatic logic is_frozen();
    return windows != 0 || (armed && loops != 0 && guests == 0);
  endfunction

  function automatic logic [63:0] guest_clock(logic [63:0] ns);
    return running ? clock_ofs + (stamp != 0 ? stamp : ns) : clock_ofs;
  endfunction

  function automatic logic [63:0] free_ticks(logic [63:0] hticks);
    logic [63:0] t;
    t = running ? tick_ofs + hticks : tick_ofs;
    if ((prev_ticks ^ SIGN_BIT) > (t ^ SIGN_BIT)) begin
      tick_ofs = tick_ofs + (prev_ticks - t);
      t = prev_ticks;
    end
    prev_ticks = t;
    return t;
  endfunction

  function automatic logic step_counter(ref logic [63:0] ctr, input logic up,
                                        input logic [63:0] ns);
    logic was, now;
    was = is_frozen();
    if (up) begin
      if (ctr >= CTR_MAX) return 1'b1;
      ctr = ctr + 1;
    end else begin
      if (ctr == 0) return 1'b1;
      ctr = ctr - 1;
    end
    now = is_frozen();
    if (was != now) begin
      if (now) stamp = ns;
      else if (stamp != 0) begin
        if (running) clock_ofs = clock_ofs - (ns - stamp);
        stamp = 0;
      end
    end
    return 1'b0;
  endfunction

  function automatic event_result_t predict_event(op_t op, logic [63:0] ns,
                                                  logic [63:0] hticks, logic [63:0] rate);
    event_result_t r;
    logic [127:0] prod;
    logic [63:0]  span;
    r = '0;
    case (op)
      OP_RD_TICKS: begin
        if (rate_lock != 0) begin
          // The clock difference wraps at 64 bits before the multiply.
          span = guest_clock(ns) - base_clock;
          prod = {64'd0, span} * {64'd0, rate_lock};
          r.value = base_ticks + prod[95:32];
        end else r.value = free_ticks(hticks);
      end
      OP_RD_CLOCK: r.value = guest_clock(ns);
      OP_ENABLE: if (!running) begin
        tick_ofs = tick_ofs - hticks;
        clock_ofs = clock_ofs - ns;
        running = 1'b1;
        stamp = is_frozen() ? ns : 64'd0;
      end
      OP_DISABLE: if (running) begin
        tick_ofs = tick_ofs + hticks;
        clock_ofs = guest_clock(ns);
        running = 1'b0;
        stamp = 0;
      end
      OP_WIN_OPEN:   r.count_error = step_counter(windows, 1'b1, ns);
      OP_WIN_CLOSE:  r.count_error = step_counter(windows, 1'b0, ns);
      OP_LOOP_ENTER: r.count_error = step_counter(loops, 1'b1, ns);
      OP_LOOP_EXIT:  r.count_error = step_counter(loops, 1'b0, ns);
      OP_EXEC_ENTER: r.count_error = step_counter(guests, 1'b1, ns);
      OP_EXEC_EXIT:  r.count_error = step_counter(guests, 1'b0, ns);
      OP_ARM: begin
        armed = 1'b1;
        if (is_frozen() && stamp == 0) stamp = ns;
      end
      OP_LOCK: if (rate != 0 && rate_lock == 0) begin
        base_ticks = free_ticks(hticks);
        base_clock = guest_clock(ns);
        rate_lock = rate;
      end
      default: ;
    endcase
    r.stopped = is_frozen();
    return r;
  endfunction

  always @(posedge clk) begin
    event_result_t exp_r, got;
    if (!rst_n) begin
      tick_ofs <= 0; clock_ofs <= 0; prev_ticks <= 0; stamp <= 0; rate_lock <= 0;
      base_ticks <= 0; base_clock <= 0; windows <= 0; loops <= 0; guests <= 0;
      running <= 0; armed <= 0; fail_count <= 0;
      result_fifo.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[63:0];
        got.stopped = out_tdata[64];
        got.count_error = out_tdata[65];
        if (result_fifo.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("unexpected word value=%h", got.value);
        end else begin
          exp_r = result_fifo.pop_front();
          if (got !== exp_r) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("mismatch: exp value=%h st=%b err=%b got value=%h st=%b err=%b",
                       exp_r.value, exp_r.stopped, exp_r.count_error,
                       got.value, got.stopped, got.count_error);
          end
        end
      end
      if (in_tvalid && in_tready)
        result_fifo.push_back(predict_event(op_t'(in_tuser), {1'b0, in_tdata[62:0]},
                                            {1'b0, in_tdata[125:63]}, in_tdata[189:126]));
    end
  end
endmodule

// ===== test/pausable_guest_clock_and_tick_counter_tb.sv =====
// Top of the testbench: clock, reset, event stimulus with random idling on both
// sides, and the verdict. Depends on pgctc_pkg, the block and pgctc_checker.
`timescale 1ns / 100ps
module pausable_guest_clock_and_tick_counter_tb;
  import pgctc_pkg::*;

  logic clk, rst_n, in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [MODE_W-1:0] in_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  int fail_count, pending;
  bit calm_phase, long_hold;
  logic [63:0] host_ns_now, host_ticks_now;

  pausable_guest_clock_and_tick_counter dut (.*);

  pgctc_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver side: random stall bursts, plus one long hold to back up the pipe.
  initial begin
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 0;
        repeat (60) @(negedge clk);
        out_tready <= 1;
        wait (!long_hold);
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_tready <= 1;
      end else out_tready <= 1;
    end
  end

  task automatic send_word(op_t op, logic [62:0] ns, logic [62:0] ticks, logic [63:0] rate);
    if (!calm_phase && !long_hold && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {2'b00, rate, ticks, ns};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Host time mostly moves forward so the frozen spans stay meaningful.
  task automatic send_timed(op_t op, logic [63:0] rate);
    host_ns_now = host_ns_now + $urandom_range(0, 5000);
    host_ticks_now = host_ticks_now + $urandom_range(0, 9000);
    send_word(op, host_ns_now[62:0], host_ticks_now[62:0], rate);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int n;
    op_t op;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    calm_phase = 0; long_hold = 0;
    host_ns_now = 1000; host_ticks_now = 1000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // Directed: reads while disabled, every mode, underflows, zero stamp, extremes.
    send_word(OP_RD_TICKS, '1, '1, '1);
    send_word(OP_RD_CLOCK, '1, '1, '0);
    send_word(OP_WIN_CLOSE, 5, 5, 0);
    send_word(OP_LOOP_EXIT, 5, 5, 0);
    send_word(OP_EXEC_EXIT, 5, 5, 0);
    send_word(OP_ENABLE, 100, 200, 0);
    send_word(OP_ENABLE, 150, 250, 0);
    send_word(OP_WIN_OPEN, 0, 300, 0);
    send_word(OP_RD_CLOCK, 400, 400, 0);
    send_word(OP_WIN_CLOSE, 500, 500, 0);
    send_word(OP_LOOP_ENTER, 600, 600, 0);
    send_word(OP_ARM, 700, 700, 0);
    send_word(OP_RD_CLOCK, 800, 800, 0);
    send_word(OP_EXEC_ENTER, 900, 900, 0);
    send_word(OP_RD_TICKS, 950, 100, 0);
    send_word(OP_DISABLE, 1000, 1000, 0);
    send_word(OP_DISABLE, 1100, 1100, 0);
    send_word(OP_RD_TICKS, 1200, 1200, 0);
    send_word(op_t'(4'd12), 1, 1, 1);
    send_word(op_t'(4'd15), '1, '1, '1);
    send_word(OP_ENABLE, 1300, 1300, 0);
    send_word(OP_LOCK, 1400, 1400, 0);
    send_word(OP_RD_TICKS, 1500, 1500, 0);
    // Pause until all results are back.
    in_tvalid <= 0;
    wait (pending == 0);
    @(negedge clk);
    long_hold = 1;
    for (n = 0; n < 40; n++) send_timed(OP_RD_CLOCK, 0);
    long_hold = 0;
    for (n = 0; n < 1000; n++) begin
      if (n == 850) calm_phase = 1;
      if (n == 500) send_timed(OP_LOCK, $urandom_range(0, 3) == 0 ? '1 : rnd64());
      if ($urandom_range(0, 19) == 0)
        send_word(op_t'($urandom_range(0, 15)), 63'(rnd64()), 63'(rnd64()), rnd64());
      else begin
        op = op_t'($urandom_range(0, 10));
        if (n > 500 && $urandom_range(0, 3) == 0) op = OP_RD_TICKS;
        send_timed(op, 0);
      end
    end
    in_tvalid <= 0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
